// ===== hw/rtl/ypp_pkg.sv =====
// ----------------------------------------------------------------------------
// ypp_pkg: shared types and constants for the yaw/pitch perspective projector
// Widths of the fixed-point datapath, CORDIC table, status and register codes.
// ----------------------------------------------------------------------------
package ypp_pkg;

  // angle resolution kept by the CORDIC (8..24)
  localparam int ANGLE_BITS = 16;
  localparam int ITER_W     = $clog2(ANGLE_BITS);
  localparam logic [31:0] ANG_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  localparam int CW      = 34;   // CORDIC x/y/z width, x/y in Q30
  localparam int TRIG_W  = 32;   // sine/cosine, Q28
  localparam int COORD_W = 32;   // Q16.16 coordinates
  localparam int FOV_W   = 31;
  localparam int REL_W   = COORD_W + 1;
  localparam int FRAC    = 28;
  localparam int ROT_W   = 36;   // rotated x and z
  localparam int DEP_W   = 37;   // depth
  localparam int DEN_W   = 38;   // depth + fov
  localparam int NUM_W   = ROT_W + FOV_W;
  localparam int QB      = 33;   // quotient bits resolved by the divider
  localparam int REM_W   = DEN_W;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // register indexes
  localparam int CFG_W = 3;
  localparam logic [CFG_W-1:0] CFG_CAM_X = 3'd0;
  localparam logic [CFG_W-1:0] CFG_CAM_Y = 3'd1;
  localparam logic [CFG_W-1:0] CFG_CAM_Z = 3'd2;
  localparam logic [CFG_W-1:0] CFG_PITCH = 3'd3;
  localparam logic [CFG_W-1:0] CFG_YAW   = 3'd4;
  localparam logic [CFG_W-1:0] CFG_FOV   = 3'd5;

  localparam logic [FOV_W-1:0]   FOV_RESET = 31'd65536;
  localparam logic [COORD_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG   = 32'h8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } cor_stat_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] xr;
    logic signed [ROT_W-1:0] zr;
    logic signed [DEN_W-1:0] den;
  } rot_out_t;

  typedef struct packed {
    logic [1:0][QB-1:0] q;
    logic [1:0]         ovf;
    logic [1:0]         neg;
    logic               zero;
  } div_out_t;

endpackage

// ===== hw/rtl/ypp_cordic.sv =====
// ----------------------------------------------------------------------------
// ypp_cordic: iterative sine/cosine unit
// One rotation step per cycle, ANGLE_BITS steps per angle, results in Q28.
// ----------------------------------------------------------------------------
module ypp_cordic
  import ypp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [15:0]              angle,
  output cor_stat_t                stat,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic signed [TRIG_W-1:0] cos_q
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [ITER_W-1:0]    iter_r, iter_nxt;
  logic signed [CW-1:0] x_r, x_nxt;
  logic signed [CW-1:0] y_r, y_nxt;
  logic signed [CW-1:0] z_r, z_nxt;
  logic                 neg_r, neg_nxt;

  logic [31:0]          a_turn;
  logic signed [CW-1:0] x_sh, y_sh, at, x_fin, y_fin, x_rnd, y_rnd;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    a_turn   = {angle, 16'h0000} & ANG_MASK;
    x_sh     = x_r >>> iter_r;
    y_sh     = y_r >>> iter_r;
    at       = $signed({{(CW-32){1'b0}}, ATAN_TURNS[5'(iter_r)]});
    if (start) begin
      // fold the left half-plane onto the right one
      neg_nxt = a_turn[31] ^ a_turn[30];
      if (neg_nxt) begin
        a_turn[31] = ~a_turn[31];
      end
      z_nxt    = CW'($signed(a_turn));
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      iter_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + at;
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(ANGLE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r <= iter_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    neg_r  <= neg_nxt;
  end

  always_comb begin
    x_fin = neg_r ? -x_r : x_r;
    y_fin = neg_r ? -y_r : y_r;
    x_rnd = (x_fin + CW'(2)) >>> 2;
    y_rnd = (y_fin + CW'(2)) >>> 2;
  end

  assign cos_q     = x_rnd[TRIG_W-1:0];
  assign sin_q     = y_rnd[TRIG_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== hw/rtl/ypp_rotate.sv =====
// ----------------------------------------------------------------------------
// ypp_rotate: camera-relative rotation pipeline
// Six stages: subtract, yaw products, yaw sums, pitch products, depth, denominator.
// ----------------------------------------------------------------------------
module ypp_rotate
  import ypp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_acc,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  logic signed [COORD_W-1:0] cam_x,
  input  logic signed [COORD_W-1:0] cam_y,
  input  logic signed [COORD_W-1:0] cam_z,
  input  logic signed [TRIG_W-1:0]  sin_yaw,
  input  logic signed [TRIG_W-1:0]  cos_yaw,
  input  logic signed [TRIG_W-1:0]  sin_pitch,
  input  logic signed [TRIG_W-1:0]  cos_pitch,
  input  logic [FOV_W-1:0]          fov,
  output logic                      rot_valid,
  output rot_out_t                  rot
);

  localparam int PW  = REL_W + TRIG_W;
  localparam int PZW = ROT_W + TRIG_W;

  logic [5:0] vld_r;

  logic signed [REL_W-1:0] rx_r, ry_r, rz_r, ry2_r, ry3_r;
  logic signed [PW-1:0]    mxc_r, mzs_r, mxs_r, mzc_r, pry_r;
  logic signed [PZW-1:0]   pzr_r;
  logic signed [ROT_W-1:0] xr3_r, zr3_r, xr4_r, zr4_r, xr5_r, zr5_r, xr6_r, zr6_r;
  logic signed [DEP_W-1:0] d5_r;
  logic signed [DEN_W-1:0] den6_r;

  logic signed [PW:0]  sum_x, sum_z;
  logic signed [PZW:0] sum_d;

  always_comb begin
    sum_x = (PW+1)'(mxc_r) - (PW+1)'(mzs_r);
    sum_z = (PW+1)'(mxs_r) + (PW+1)'(mzc_r);
    sum_d = (PZW+1)'(pry_r) - (PZW+1)'(pzr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r   <= REL_W'(px) - REL_W'(cam_x);
      ry_r   <= REL_W'(py) - REL_W'(cam_y);
      rz_r   <= REL_W'(pz) - REL_W'(cam_z);
      mxc_r  <= rx_r * cos_yaw;
      mzs_r  <= rz_r * sin_yaw;
      mxs_r  <= rx_r * sin_yaw;
      mzc_r  <= rz_r * cos_yaw;
      ry2_r  <= ry_r;
      xr3_r  <= sum_x[FRAC+ROT_W-1:FRAC];
      zr3_r  <= sum_z[FRAC+ROT_W-1:FRAC];
      ry3_r  <= ry2_r;
      pry_r  <= ry3_r * cos_pitch;
      pzr_r  <= zr3_r * sin_pitch;
      xr4_r  <= xr3_r;
      zr4_r  <= zr3_r;
      d5_r   <= sum_d[FRAC+DEP_W-1:FRAC];
      xr5_r  <= xr4_r;
      zr5_r  <= zr4_r;
      den6_r <= DEN_W'(d5_r) + $signed({{(DEN_W-FOV_W){1'b0}}, fov});
      xr6_r  <= xr5_r;
      zr6_r  <= zr5_r;
    end
  end

  assign rot_valid = vld_r[5];
  assign rot.xr    = xr6_r;
  assign rot.zr    = zr6_r;
  assign rot.den   = den6_r;

endmodule

// ===== hw/rtl/ypp_div.sv =====
// ----------------------------------------------------------------------------
// ypp_div: pipelined scale-and-divide for both screen coordinates
// Magnitudes, fov product, range check, then one restoring quotient bit a stage.
// ----------------------------------------------------------------------------
module ypp_div
  import ypp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             rot_valid,
  input  rot_out_t         rot,
  input  logic [FOV_W-1:0] fov,
  output logic             div_valid,
  output div_out_t         dout
);

  typedef struct packed {
    logic [1:0][REM_W-1:0] rem;
    logic [1:0][QB-1:0]    nlow;
    logic [1:0][QB-1:0]    q;
    logic [1:0]            ovf;
    logic [1:0]            neg;
    logic                  zero;
    logic [DEN_W-1:0]      dmag;
  } it_t;

  function automatic it_t div_step(input it_t s);
    it_t            n;
    logic [REM_W:0] trial;
    n = s;
    for (int l = 0; l < 2; l++) begin
      trial     = {s.rem[l], s.nlow[l][QB-1]};
      n.nlow[l] = {s.nlow[l][QB-2:0], 1'b0};
      if (trial >= {1'b0, s.dmag}) begin
        n.rem[l] = REM_W'(trial - {1'b0, s.dmag});
        n.q[l]   = {s.q[l][QB-2:0], 1'b1};
      end else begin
        n.rem[l] = REM_W'(trial);
        n.q[l]   = {s.q[l][QB-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  logic [1:0]            vld_r;
  logic [QB:0]           it_vld_r;
  logic [1:0][ROT_W-1:0] mag_r;
  logic [1:0]            neg1_r, neg2_r;
  logic [DEN_W-1:0]      dmag1_r, dmag2_r;
  logic                  zero1_r, zero2_r;
  logic [1:0][NUM_W-1:0] num_r;
  it_t                   it_r [0:QB];
  it_t                   it0_nxt;

  logic signed [ROT_W-1:0] lane_val [2];

  assign lane_val[0] = rot.xr;
  assign lane_val[1] = rot.zr;

  always_comb begin
    it0_nxt      = '0;
    it0_nxt.neg  = neg2_r;
    it0_nxt.zero = zero2_r;
    it0_nxt.dmag = dmag2_r;
    for (int l = 0; l < 2; l++) begin
      // quotient would need more than QB bits
      it0_nxt.ovf[l]  = (NUM_W+DEN_W+QB)'(num_r[l]) >= (NUM_W+DEN_W+QB)'({dmag2_r, QB'(0)});
      it0_nxt.rem[l]  = REM_W'(num_r[l][NUM_W-1:QB]);
      it0_nxt.nlow[l] = num_r[l][QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      it_vld_r <= '0;
    end else if (en) begin
      vld_r    <= {vld_r[0], rot_valid};
      it_vld_r <= {it_vld_r[QB-1:0], vld_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        mag_r[l]  <= lane_val[l][ROT_W-1] ? ROT_W'(-lane_val[l]) : ROT_W'(lane_val[l]);
        neg1_r[l] <= lane_val[l][ROT_W-1] ^ rot.den[DEN_W-1];
        num_r[l]  <= NUM_W'(mag_r[l]) * NUM_W'(fov);
      end
      dmag1_r <= rot.den[DEN_W-1] ? DEN_W'(-rot.den) : DEN_W'(rot.den);
      zero1_r <= (rot.den == '0);
      neg2_r  <= neg1_r;
      dmag2_r <= dmag1_r;
      zero2_r <= zero1_r;
      it_r[0] <= it0_nxt;
      for (int k = 0; k < QB; k++) begin
        it_r[k+1] <= div_step(it_r[k]);
      end
    end
  end

  assign div_valid = it_vld_r[QB];
  assign dout.q    = it_r[QB].q;
  assign dout.ovf  = it_r[QB].ovf;
  assign dout.neg  = it_r[QB].neg;
  assign dout.zero = it_r[QB].zero;

endmodule

// ===== hw/rtl/yaw_pitch_perspective_project.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_perspective_project: perspective projection with yaw/pitch camera
// Subtracts camera position, rotates by yaw then pitch, divides by depth + fov.
//
//   port group   direction   handshake          payload
//   in_*         in          in_valid/in_stall  point_x, point_y, point_z
//   out_*        out         out_valid/out_stall screen_u, screen_v, status
//   cfg_*        in          cfg_wr_en          cfg_index, cfg_data
//
// One request per cycle while in_stall is low; 6 rotate stages, 3 divider front end,
// 33 quotient stages and 1 output register.
// After reset and after each angle write the shared CORDIC recomputes yaw then
// pitch, ANGLE_BITS steps each, with in_stall high.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module yaw_pitch_perspective_project
  import ypp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_screen_u,
  output logic signed [COORD_W-1:0] out_screen_v,
  output logic [1:0]                out_status,
  input  logic                      cfg_wr_en,
  input  logic [CFG_W-1:0]          cfg_index,
  input  logic [COORD_W-1:0]        cfg_data
);

  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_YAW   = 2'd1;
  localparam logic [1:0] SEQ_PITCH = 2'd2;

  logic signed [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [15:0]               pitch_r, yaw_r;
  logic [FOV_W-1:0]          fov_r;

  logic [1:0] seq_r, seq_nxt;
  logic       req_r, req_nxt;
  logic       angle_wr, cor_start, trig_busy;
  logic [15:0] cor_angle;
  cor_stat_t  cor_stat;
  logic signed [TRIG_W-1:0] cor_sin, cor_cos;
  logic signed [TRIG_W-1:0] sin_yaw_r, cos_yaw_r, sin_pitch_r, cos_pitch_r;

  logic     pipe_en, in_acc, rot_valid, div_valid;
  rot_out_t rot;
  div_out_t dout;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] u_r, v_r, u_nxt, v_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [1:0]                lane_sat;
  logic [1:0][COORD_W-1:0]   lane_res;

  // configuration registers
  assign angle_wr = cfg_wr_en && (cfg_index == CFG_PITCH || cfg_index == CFG_YAW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      fov_r   <= FOV_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CAM_X: cam_x_r <= cfg_data;
        CFG_CAM_Y: cam_y_r <= cfg_data;
        CFG_CAM_Z: cam_z_r <= cfg_data;
        CFG_PITCH: pitch_r <= cfg_data[15:0];
        CFG_YAW:   yaw_r   <= cfg_data[15:0];
        CFG_FOV:   fov_r   <= cfg_data[FOV_W-1:0];
        default:   ;
      endcase
    end
  end

  // trig sequencer: yaw first, then pitch
  always_comb begin
    seq_nxt   = seq_r;
    cor_start = 1'b0;
    cor_angle = yaw_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (req_r) begin
          cor_start = 1'b1;
          seq_nxt   = SEQ_YAW;
        end
      end
      SEQ_YAW: begin
        if (cor_stat.done) begin
          cor_start = 1'b1;
          cor_angle = pitch_r;
          seq_nxt   = SEQ_PITCH;
        end
      end
      SEQ_PITCH: begin
        if (cor_stat.done) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
    req_nxt = angle_wr || (req_r && !(seq_r == SEQ_IDLE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_IDLE;
      req_r <= 1'b1;
    end else begin
      seq_r <= seq_nxt;
      req_r <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cor_stat.done && seq_r == SEQ_YAW) begin
      sin_yaw_r <= cor_sin;
      cos_yaw_r <= cor_cos;
    end
    if (cor_stat.done && seq_r == SEQ_PITCH) begin
      sin_pitch_r <= cor_sin;
      cos_pitch_r <= cor_cos;
    end
  end

  assign trig_busy = req_r || (seq_r != SEQ_IDLE);

  ypp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .stat  (cor_stat),
    .sin_q (cor_sin),
    .cos_q (cor_cos)
  );

  // pipeline advance
  assign pipe_en  = !out_valid_r || !out_stall;
  assign in_stall = !pipe_en || trig_busy;
  assign in_acc   = in_valid && !in_stall;

  ypp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_acc    (in_acc),
    .px        (in_point_x),
    .py        (in_point_y),
    .pz        (in_point_z),
    .cam_x     (cam_x_r),
    .cam_y     (cam_y_r),
    .cam_z     (cam_z_r),
    .sin_yaw   (sin_yaw_r),
    .cos_yaw   (cos_yaw_r),
    .sin_pitch (sin_pitch_r),
    .cos_pitch (cos_pitch_r),
    .fov       (fov_r),
    .rot_valid (rot_valid),
    .rot       (rot)
  );

  ypp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .rot_valid (rot_valid),
    .rot       (rot),
    .fov       (fov_r),
    .div_valid (div_valid),
    .dout      (dout)
  );

  // sign and clamp
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dout.neg[l]) begin
        lane_sat[l] = dout.ovf[l] || (dout.q[l] > {1'b0, SAT_NEG});
        lane_res[l] = lane_sat[l] ? SAT_NEG : COORD_W'(0) - dout.q[l][COORD_W-1:0];
      end else begin
        lane_sat[l] = dout.ovf[l] || (dout.q[l] > {1'b0, SAT_POS});
        lane_res[l] = lane_sat[l] ? SAT_POS : dout.q[l][COORD_W-1:0];
      end
    end
    if (dout.zero) begin
      u_nxt      = '0;
      v_nxt      = '0;
      status_nxt = ST_ZERO;
    end else begin
      u_nxt      = lane_res[0];
      v_nxt      = lane_res[1];
      status_nxt = (lane_sat != 2'b00) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && div_valid) begin
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_u = u_r;
  assign out_screen_v = v_r;
  assign out_status   = status_r;

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    trig_busy |-> in_stall)
    else $error("input taken while trig values are being recomputed");

  a_idle_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_IDLE) |-> !cor_stat.busy)
    else $error("CORDIC running with sequencer idle");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_ZERO) |-> (u_r == '0 && v_r == '0))
    else $error("zero denominator with nonzero outputs");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_OK || status_r == ST_ZERO || status_r == ST_SAT))
    else $error("undefined status code");

endmodule
